// File: hw/rtl/prle_pkg.sv
package prle_pkg;

    // Code format
    localparam int MAX_CHUNK = 128;
    localparam int OUT_LANES = 8;
    localparam logic [7:0] END_CODE = 8'd128;
    localparam logic [8:0] RUN_BASE = 9'd257;

    // Derived sizes
    localparam int CNT_W    = 8;
    localparam int LIT_DEPTH = MAX_CHUNK;
    localparam int LIT_AW   = $clog2(LIT_DEPTH);
    localparam int PACK_W   = OUT_LANES * 8;
    localparam int PACK_CW  = $clog2(OUT_LANES + 1);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [63:0] out_bytes;
        logic [3:0]  out_count;
        logic        out_last;
        logic        out_stream_end;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_CLOSE,
        ST_AFTER_CLOSE,
        ST_LAST_CHK,
        ST_LIT_HDR,
        ST_LIT_DATA,
        ST_RUN_HDR,
        ST_RUN_VAL,
        ST_END,
        ST_FINISH
    } t_state;

    typedef enum logic [2:0] {
        EM_LIT_HDR,
        EM_LIT_DATA,
        EM_RUN_HDR,
        EM_RUN_VAL,
        EM_END
    } t_emit_sel;

    typedef struct packed {
        logic      in_load;
        logic      run_inc;
        logic      chunk_apply;
        logic      close_clear;
        logic      load_new;
        logic      store_append;
        logic      lit_start;
        logic      lit_next;
        logic      lit_clear;
        logic      held_clear;
        logic      emit;
        t_emit_sel emit_sel;
        logic      finish;
    } t_dp_cmd;

    typedef struct packed {
        logic match;
        logic chunk_hit;
        logic held_valid;
        logic run_len_zero;
        logic run_len_ge2;
        logic run_cont;
        logic lit_empty;
        logic lit_full_next;
        logic lit_done;
        logic push_ok;
        logic out_free;
        logic pack_empty;
        logic in_last;
    } t_dp_stat;

endpackage

// File: hw/rtl/prle_ram.sv
module prle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port, registered read port that holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/prle_dp.sv
module prle_dp
    import prle_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    t_in_item               r_in;
    logic [7:0]             r_held_byte;
    logic                   r_held_valid;
    logic [CNT_W-1:0]       r_run_len;
    logic                   r_run_cont;
    logic [CNT_W-1:0]       r_lit_count;
    logic [CNT_W-1:0]       r_lit_idx;
    logic [PACK_W-1:0]      r_pack;
    logic [PACK_W-1:0]      n_pack;
    logic [PACK_CW-1:0]     r_pack_cnt;
    logic [PACK_CW-1:0]     pack_lane;
    logic                   pack_full;
    logic                   r_out_valid;
    t_out_item              r_out;
    logic [7:0]             rd_data;
    logic [LIT_AW-1:0]      rd_addr;
    logic                   rd_en;
    logic [7:0]             emit_byte;
    logic                   out_free;
    logic                   push_ok;
    logic                   push_fire;
    logic                   finish_fire;

    // Literal store
    assign rd_en   = i_cmd.lit_start | i_cmd.lit_next;
    assign rd_addr = i_cmd.lit_start ? '0 : r_lit_idx[LIT_AW-1:0];

    prle_ram #(
        .WIDTH (8),
        .DEPTH (LIT_DEPTH)
    ) u_lit_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.store_append),
        .i_wr_addr (r_lit_count[LIT_AW-1:0]),
        .i_wr_data (r_held_byte),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Select the code byte for this cycle
    always_comb begin
        unique case (i_cmd.emit_sel)
            EM_LIT_HDR:  emit_byte = 8'(r_lit_count - CNT_W'(1));
            EM_LIT_DATA: emit_byte = rd_data;
            EM_RUN_HDR:  emit_byte = 8'(RUN_BASE - {1'b0, r_run_len});
            EM_RUN_VAL:  emit_byte = r_held_byte;
            EM_END:      emit_byte = END_CODE;
            default:     emit_byte = END_CODE;
        endcase
    end

    // Packer handshake
    assign pack_full   = (r_pack_cnt == PACK_CW'(OUT_LANES));
    assign out_free    = !r_out_valid || !i_out_stall;
    assign push_ok     = !pack_full || out_free;
    assign push_fire   = i_cmd.emit && push_ok;
    assign finish_fire = i_cmd.finish && out_free && (r_pack_cnt != '0);
    assign pack_lane   = pack_full ? '0 : r_pack_cnt;

    // Place the byte in its lane; a fresh word starts from zero
    always_comb begin
        n_pack = (r_pack_cnt == '0 || pack_full) ? '0 : r_pack;
        for (int l = 0; l < OUT_LANES; l++) begin
            if (pack_lane == PACK_CW'(l)) begin
                n_pack[8*l +: 8] = emit_byte;
            end
        end
    end

    // Run and literal bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_byte  <= '0;
            r_held_valid <= 1'b0;
            r_run_len    <= '0;
            r_run_cont   <= 1'b0;
            r_lit_count  <= '0;
        end else begin
            if (i_cmd.run_inc) begin
                r_run_len <= r_run_len + CNT_W'(1);
            end
            if (i_cmd.chunk_apply) begin
                r_run_len  <= '0;
                r_run_cont <= 1'b1;
            end
            if (i_cmd.close_clear) begin
                r_held_valid <= 1'b0;
                r_run_len    <= '0;
                r_run_cont   <= 1'b0;
            end
            if (i_cmd.load_new) begin
                r_held_byte  <= r_in.in_byte;
                r_held_valid <= 1'b1;
                r_run_len    <= CNT_W'(1);
                r_run_cont   <= 1'b0;
            end
            if (i_cmd.held_clear) begin
                r_held_byte <= '0;
            end
            if (i_cmd.store_append) begin
                r_lit_count <= r_lit_count + CNT_W'(1);
            end
            if (i_cmd.lit_clear) begin
                r_lit_count <= '0;
            end
        end
    end

    // Capture request, step the store read index
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_in <= i_in;
        end
        if (i_cmd.lit_start) begin
            r_lit_idx <= CNT_W'(1);
        end else if (i_cmd.lit_next) begin
            r_lit_idx <= r_lit_idx + CNT_W'(1);
        end
    end

    // Packer count and output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pack_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (push_fire) begin
                r_pack_cnt <= pack_full ? PACK_CW'(1) : r_pack_cnt + PACK_CW'(1);
            end else if (finish_fire) begin
                r_pack_cnt <= '0;
            end
            if ((push_fire && pack_full) || finish_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Packer word and output payload
    always_ff @(posedge i_clk) begin
        if (push_fire) begin
            r_pack <= n_pack;
        end
        if (push_fire && pack_full) begin
            r_out.out_bytes      <= 64'(r_pack);
            r_out.out_count      <= 4'(OUT_LANES);
            r_out.out_last       <= 1'b0;
            r_out.out_stream_end <= 1'b0;
        end else if (finish_fire) begin
            r_out.out_bytes      <= 64'(r_pack);
            r_out.out_count      <= 4'(r_pack_cnt);
            r_out.out_last       <= 1'b1;
            r_out.out_stream_end <= r_in.in_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Status to the controller
    always_comb begin
        o_stat.match         = r_held_valid && (r_in.in_byte == r_held_byte);
        o_stat.chunk_hit     = ({1'b0, r_run_len} + 9'd1) >= 9'(MAX_CHUNK);
        o_stat.held_valid    = r_held_valid;
        o_stat.run_len_zero  = (r_run_len == '0);
        o_stat.run_len_ge2   = (r_run_len >= CNT_W'(2));
        o_stat.run_cont      = r_run_cont;
        o_stat.lit_empty     = (r_lit_count == '0);
        o_stat.lit_full_next = ({1'b0, r_lit_count} + 9'd1) >= 9'(MAX_CHUNK);
        o_stat.lit_done      = (r_lit_idx == r_lit_count);
        o_stat.push_ok       = push_ok;
        o_stat.out_free      = out_free;
        o_stat.pack_empty    = (r_pack_cnt == '0);
        o_stat.in_last       = r_in.in_last;
    end

endmodule

// File: hw/rtl/prle_ctrl.sv
module prle_ctrl
    import prle_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    t_state r_ret;
    t_state n_ret;
    logic   r_chunk;
    logic   n_chunk;
    logic   r_phase_last;
    logic   n_phase_last;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ret        <= ST_IDLE;
            r_chunk      <= 1'b0;
            r_phase_last <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_ret        <= n_ret;
            r_chunk      <= n_chunk;
            r_phase_last <= n_phase_last;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        n_ret        = r_ret;
        n_chunk      = r_chunk;
        n_phase_last = r_phase_last;
        o_cmd        = '0;
        o_cmd.emit_sel = EM_END;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.in_load = 1'b1;
                    n_phase_last  = 1'b0;
                    n_state       = ST_DECIDE;
                end
            end

            // Extend the open run or close it
            ST_DECIDE: begin
                if (i_stat.match) begin
                    o_cmd.run_inc = 1'b1;
                    if (i_stat.chunk_hit) begin
                        n_chunk = 1'b1;
                        n_ret   = ST_RUN_HDR;
                        n_state = ST_LIT_HDR;
                    end else begin
                        n_state = ST_LAST_CHK;
                    end
                end else begin
                    n_state = ST_CLOSE;
                end
            end

            // Close the open run: send it, or move a single byte to the store
            ST_CLOSE: begin
                priority if (!i_stat.held_valid || i_stat.run_len_zero) begin
                    n_state = ST_AFTER_CLOSE;
                end else if (i_stat.run_len_ge2) begin
                    n_chunk = 1'b0;
                    n_ret   = ST_RUN_HDR;
                    n_state = ST_LIT_HDR;
                end else if (i_stat.run_cont) begin
                    n_chunk = 1'b0;
                    n_state = ST_RUN_HDR;
                end else begin
                    o_cmd.store_append = 1'b1;
                    if (i_stat.lit_full_next) begin
                        n_ret   = ST_AFTER_CLOSE;
                        n_state = ST_LIT_HDR;
                    end else begin
                        n_state = ST_AFTER_CLOSE;
                    end
                end
            end

            ST_AFTER_CLOSE: begin
                if (!r_phase_last) begin
                    o_cmd.load_new = 1'b1;
                    n_state        = ST_LAST_CHK;
                end else begin
                    o_cmd.close_clear = 1'b1;
                    n_ret             = ST_END;
                    n_state           = ST_LIT_HDR;
                end
            end

            ST_LAST_CHK: begin
                if (i_stat.in_last) begin
                    n_phase_last = 1'b1;
                    n_state      = ST_CLOSE;
                end else begin
                    n_state = ST_FINISH;
                end
            end

            // Literal flush: header, then the stored bytes
            ST_LIT_HDR: begin
                if (i_stat.lit_empty) begin
                    n_state = r_ret;
                end else begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EM_LIT_HDR;
                    if (i_stat.push_ok) begin
                        o_cmd.lit_start = 1'b1;
                        n_state         = ST_LIT_DATA;
                    end
                end
            end

            ST_LIT_DATA: begin
                o_cmd.emit     = 1'b1;
                o_cmd.emit_sel = EM_LIT_DATA;
                if (i_stat.push_ok) begin
                    if (i_stat.lit_done) begin
                        o_cmd.lit_clear = 1'b1;
                        n_state         = r_ret;
                    end else begin
                        o_cmd.lit_next = 1'b1;
                    end
                end
            end

            // Run: header, then value
            ST_RUN_HDR: begin
                o_cmd.emit     = 1'b1;
                o_cmd.emit_sel = EM_RUN_HDR;
                if (i_stat.push_ok) begin
                    n_state = ST_RUN_VAL;
                end
            end

            ST_RUN_VAL: begin
                o_cmd.emit     = 1'b1;
                o_cmd.emit_sel = EM_RUN_VAL;
                if (i_stat.push_ok) begin
                    if (r_chunk) begin
                        o_cmd.chunk_apply = 1'b1;
                        n_state           = ST_LAST_CHK;
                    end else begin
                        n_state = ST_AFTER_CLOSE;
                    end
                end
            end

            ST_END: begin
                o_cmd.emit     = 1'b1;
                o_cmd.emit_sel = EM_END;
                if (i_stat.push_ok) begin
                    o_cmd.held_clear = 1'b1;
                    n_state          = ST_FINISH;
                end
            end

            // Hand off the partial word as the closing item of this request
            ST_FINISH: begin
                if (i_stat.pack_empty) begin
                    n_state = ST_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/packbits_run_length_encoder.sv
// Flow: a byte that extends a run passes the decide, last-check and finish states before the
// input is freed; one that opens a run also passes the close and after-close states. Code
// bytes are emitted one at a time, a literal flush with its header first, and may stall.
// Requests: one at a time; the input stays stalled until the controller is idle again.
// Reset: synchronous, active low; clears run and literal counts and the output valid.
// The literal store is not cleared; only entries below the literal count are read.
module packbits_run_length_encoder
    import prle_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    prle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    prle_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

// File: hw/rtl/prle_chk.sv
module prle_chk
    import prle_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out
);

    // Byte count of an item is within the lane range
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.out_count != 4'd0) && (o_out.out_count <= 4'(OUT_LANES)))
        else $error("out_count out of range");

    // Only the closing item of a request may be partly filled
    a_full_unless_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.out_last) |-> (o_out.out_count == 4'(OUT_LANES)))
        else $error("non-closing item not full");

    // End-of-data byte only in the closing item
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.out_stream_end) |-> o_out.out_last)
        else $error("stream end on non-closing item");

    // A taken request blocks the next one
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken while busy");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled result changed");

endmodule

bind packbits_run_length_encoder prle_chk u_prle_chk (.*);

// File: sim/tb_packbits_run_length_encoder.sv
`timescale 1ns / 100ps

module tb_packbits_run_length_encoder;
    import prle_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 64;
    localparam int PHASE_REQS   = 12;
    localparam int MAX_PRINTS   = 40;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out;

    packbits_run_length_encoder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    // Encoder mirror: open run, literal store, code bytes of one request
    logic [7:0] run_val;
    logic       run_open;
    logic [7:0] run_len;
    logic       run_cont;
    logic [7:0] lit_buf [128];
    logic [7:0] lit_cnt;
    logic [7:0] code_bytes [$];
    t_out_item  step_codes [$];
    t_out_item  expected_codes [$];

    // Directed rows and planned random streams
    t_in_item   dir_req [$];
    logic       dir_typed [$];
    t_out_item  dir_want [$];
    t_in_item   stream_q [$];

    int  mismatch_cnt;
    int  request_cnt;
    int  code_item_cnt;
    int  stream_cnt;
    int  phase_reqs;
    int  cycle_cnt;
    int  tx_idle_pct;
    int  rx_idle_pct;
    logic hold_go;
    logic hold_done;
    int  hold_left;

    always #4 i_clk = ~i_clk;

    function automatic t_in_item mk_req(input logic [7:0] b, input logic l);
        t_in_item r;
        r.in_byte = b;
        r.in_last = l;
        return r;
    endfunction

    function automatic void emit_literals();
        if (lit_cnt != 0) begin
            code_bytes.insert(code_bytes.size(), lit_cnt - 8'd1);
            for (int i = 0; i < lit_cnt; i++)
                code_bytes.insert(code_bytes.size(), lit_buf[i]);
            lit_cnt = 0;
        end
    endfunction

    function automatic void emit_run(input logic [7:0] len, input logic [7:0] val);
        logic [8:0] hdr;
        hdr = RUN_BASE - {1'b0, len};
        code_bytes.insert(code_bytes.size(), hdr[7:0]);
        code_bytes.insert(code_bytes.size(), val);
    endfunction

    function automatic void close_run();
        if (run_open) begin
            if (run_len >= 8'd2) begin
                emit_literals();
                emit_run(run_len, run_val);
            end else if (run_len == 8'd1) begin
                if (run_cont) begin
                    emit_run(8'd1, run_val);
                end else begin
                    lit_buf[lit_cnt[6:0]] = run_val;
                    lit_cnt = lit_cnt + 8'd1;
                    if (lit_cnt >= MAX_CHUNK)
                        emit_literals();
                end
            end
        end
        run_open = 1'b0;
        run_len  = 8'd0;
        run_cont = 1'b0;
    endfunction

    // Advance the mirror by one request and pack its code bytes into step_codes
    function automatic void encode_byte(input t_in_item req);
        int n;
        int k;
        int cnt;
        t_out_item item;
        code_bytes.delete();
        step_codes.delete();
        if (run_open && req.in_byte == run_val) begin
            run_len = run_len + 8'd1;
            if (run_len >= MAX_CHUNK) begin
                emit_literals();
                emit_run(run_len, run_val);
                run_len  = 8'd0;
                run_cont = 1'b1;
            end
        end else begin
            close_run();
            run_val  = req.in_byte;
            run_open = 1'b1;
            run_len  = 8'd1;
            run_cont = 1'b0;
        end
        if (req.in_last) begin
            close_run();
            emit_literals();
            code_bytes.insert(code_bytes.size(), END_CODE);
            run_val = 8'd0;
        end
        n = code_bytes.size();
        k = 0;
        while (k < n) begin
            item = '0;
            cnt = (n - k > OUT_LANES) ? OUT_LANES : n - k;
            for (int j = 0; j < cnt; j++)
                item.out_bytes[8*j +: 8] = code_bytes[k + j];
            item.out_count      = 4'(cnt);
            item.out_last       = (k + cnt == n);
            item.out_stream_end = req.in_last && (k + cnt == n);
            step_codes.insert(step_codes.size(), item);
            k = k + cnt;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_PRINTS)
            $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
    endtask

    task automatic add_row(input logic [7:0] b, input logic l,
                           input logic [63:0] wb, input logic [3:0] wc);
        t_out_item w;
        w.out_bytes      = wb;
        w.out_count      = wc;
        w.out_last       = 1'b1;
        w.out_stream_end = 1'b1;
        dir_req.insert(dir_req.size(), mk_req(b, l));
        dir_typed.insert(dir_typed.size(), wc != 4'd0);
        dir_want.insert(dir_want.size(), w);
    endtask

    // Offer one request, hold it until taken, then record what it must produce
    task automatic send_request(input t_in_item req, input logic typed,
                                input t_out_item want);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= req;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        encode_byte(req);
        if (typed)
            expected_codes.insert(expected_codes.size(), want);
        else
            foreach (step_codes[i])
                expected_codes.insert(expected_codes.size(), step_codes[i]);
        request_cnt++;
    endtask

    // Drop valid and wait until every outstanding code item has come back
    task automatic park_sender();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_codes.size() != 0)
            @(posedge i_clk);
    endtask

    // Plan one stream: runs and literal stretches with random content
    task automatic plan_stream(input logic forced);
        int segs;
        int kind;
        int len;
        int cut;
        logic [7:0] prev;
        prev = 8'($urandom_range(255));
        if (forced) begin
            // literal store overflow, then a run one byte past a full chunk
            repeat (129) begin
                prev = prev + 8'($urandom_range(1, 255));
                stream_q.insert(stream_q.size(), mk_req(prev, 1'b0));
            end
            prev = prev + 8'($urandom_range(1, 255));
            repeat (129)
                stream_q.insert(stream_q.size(), mk_req(prev, 1'b0));
        end
        segs = $urandom_range(1, 6);
        repeat (segs) begin
            kind = $urandom_range(99);
            if (kind < 40) begin
                len  = $urandom_range(2, 6);
                prev = prev + 8'($urandom_range(1, 255));
                repeat (len)
                    stream_q.insert(stream_q.size(), mk_req(prev, 1'b0));
            end else if (kind < 85) begin
                len = $urandom_range(1, 10);
                repeat (len) begin
                    prev = prev + 8'($urandom_range(1, 255));
                    stream_q.insert(stream_q.size(), mk_req(prev, 1'b0));
                end
            end else begin
                // noise byte, may extend a run
                prev = 8'($urandom_range(255));
                stream_q.insert(stream_q.size(), mk_req(prev, 1'b0));
            end
        end
        // now and then cut the stream short
        if (!forced && $urandom_range(9) == 0) begin
            cut = $urandom_range(0, stream_q.size() - 1);
            while (stream_q.size() > cut + 1)
                void'(stream_q.pop_back());
        end
        stream_q[stream_q.size() - 1].in_last = 1'b1;
    endtask

    task automatic send_stream();
        t_in_item req;
        while (stream_q.size() != 0) begin
            req = stream_q.pop_front();
            send_request(req, 1'b0, '0);
            phase_reqs++;
        end
        stream_cnt++;
    endtask

    // Receiver stall: one long hold on request, random otherwise
    always @(posedge i_clk) begin
        if (hold_go && !hold_done) begin
            hold_done   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // Check each delivered code item against the oldest expectation
    always @(posedge i_clk) begin : mon
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            code_item_cnt++;
            if (expected_codes.size() == 0) begin
                report_mismatch("code item with nothing expected", o_out.out_bytes, '0);
            end else begin
                want = expected_codes.pop_front();
                if (o_out.out_bytes != want.out_bytes)
                    report_mismatch("out_bytes", o_out.out_bytes, want.out_bytes);
                if (o_out.out_count != want.out_count)
                    report_mismatch("out_count", 64'(o_out.out_count), 64'(want.out_count));
                if (o_out.out_last != want.out_last)
                    report_mismatch("out_last", 64'(o_out.out_last), 64'(want.out_last));
                if (o_out.out_stream_end != want.out_stream_end)
                    report_mismatch("out_stream_end", 64'(o_out.out_stream_end),
                                    64'(want.out_stream_end));
            end
        end
    end

    // Give up on a hung run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d code items still due", cycle_cnt,
                     expected_codes.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in         = '0;
        i_out_stall  = 1'b0;
        hold_go      = 1'b0;
        hold_done    = 1'b0;
        hold_left    = 0;
        cycle_cnt    = 0;
        mismatch_cnt = 0;
        request_cnt  = 0;
        code_item_cnt = 0;
        stream_cnt   = 0;
        phase_reqs   = 0;
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        run_val      = 8'd0;
        run_open     = 1'b0;
        run_len      = 8'd0;
        run_cont     = 1'b0;
        lit_cnt      = 8'd0;

        // single bytes at both extremes, each closing its stream
        add_row(8'h00, 1'b1, 64'h0000_0000_0080_0000, 4'd3);
        add_row(8'hFF, 1'b1, 64'h0000_0000_0080_FF00, 4'd3);
        // two equal bytes form the shortest run
        add_row(8'hAA, 1'b0, '0, 4'd0);
        add_row(8'hAA, 1'b1, 64'h0000_0000_0080_AAFF, 4'd3);
        // three literals
        add_row(8'h01, 1'b0, '0, 4'd0);
        add_row(8'h02, 1'b0, '0, 4'd0);
        add_row(8'h03, 1'b1, 64'h0000_0080_0302_0102, 4'd5);
        // literals flushed ahead of runs
        add_row(8'h10, 1'b0, '0, 4'd0);
        add_row(8'h20, 1'b0, '0, 4'd0);
        add_row(8'h30, 1'b0, '0, 4'd0);
        add_row(8'h30, 1'b0, '0, 4'd0);
        add_row(8'h30, 1'b0, '0, 4'd0);
        add_row(8'h40, 1'b0, '0, 4'd0);
        add_row(8'h40, 1'b1, '0, 4'd0);
        // nine literals spill into a second code item, data byte 128 included
        add_row(8'h80, 1'b0, '0, 4'd0);
        add_row(8'h7F, 1'b0, '0, 4'd0);
        add_row(8'h01, 1'b0, '0, 4'd0);
        add_row(8'hFE, 1'b0, '0, 4'd0);
        add_row(8'h55, 1'b0, '0, 4'd0);
        add_row(8'hAA, 1'b0, '0, 4'd0);
        add_row(8'h00, 1'b0, '0, 4'd0);
        add_row(8'hFF, 1'b0, '0, 4'd0);
        add_row(8'h80, 1'b1, '0, 4'd0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, no idling
        foreach (dir_req[i])
            send_request(dir_req[i], dir_typed[i], dir_want[i]);
        park_sender();

        // random part in three phases, the first two with idling
        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 73 : 0;
            rx_idle_pct <= (phase == 0) ? 73 : (phase == 1) ? 32 : 0;
            phase_reqs = 0;
            if (phase == 2) begin
                plan_stream(1'b1);
                send_stream();
                // hold the receiver while short streams keep ending, so the block fills
                hold_go <= 1'b1;
                repeat (4) begin
                    stream_q.insert(stream_q.size(), mk_req(8'($urandom_range(255)), 1'b1));
                    send_stream();
                end
            end
            while (phase_reqs < PHASE_REQS) begin
                plan_stream(1'b0);
                send_stream();
            end
            park_sender();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests (%0d random streams), checked %0d code items", request_cnt,
                 stream_cnt, code_item_cnt);
        $display("Runs, literal flushes, full chunks, store overflow and stream ends exercised");
        if (mismatch_cnt == 0 && expected_codes.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
